// ----- rtl/jdcs_pkg.sv -----
// Package for the joystick drive command shaper: constants, controller states,
// register indexes and the command and status bundles between controller and datapath.
// Depends on nothing.
package jdcs_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 18;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RATE_LIMIT_ENABLE   = 3'd0,
    REG_INVERT_IN_REVERSE   = 3'd1,
    REG_SEPARATE_BRAKE_AXIS = 3'd2,
    REG_MAX_SPEED           = 3'd3,
    REG_MAX_ACCEL           = 3'd4,
    REG_MAX_DECEL           = 3'd5,
    REG_MAX_STEER_RATE      = 3'd6,
    REG_MAX_STEER_ANGLE     = 3'd7
  } cfg_reg_e;

  // Deadzone of 0.05 in Q16, one km/h in 1/1024 m/s, 0.01 m/s stop limit.
  localparam logic [16:0] DeadzoneQ16 = 17'd3277;
  localparam logic [8:0]  SpeedStep   = 9'd284;
  localparam logic [16:0] StopLimit   = 17'd11;

  typedef enum logic [1:0] {
    GEAR_PARK    = 2'd0,
    GEAR_REVERSE = 2'd1,
    GEAR_NEUTRAL = 2'd2,
    GEAR_DRIVE   = 2'd3
  } gear_e;

  // Both scaled products are divided by one million. The quotient is taken as
  // floor(floor(n / 64) * R / 2^47) with R = ceil(2^47 / 15625), which is exact for
  // every numerator below 2^39. R is kept as two 17-bit halves.
  localparam logic [38:0] HalfSec  = 39'd500000;
  localparam logic [16:0] RecipLo  = 17'd62487;
  localparam logic [16:0] RecipHi  = 17'd68719;
  localparam int unsigned DivNumW  = 39;
  localparam int unsigned DivQuoW  = 20;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_DIVS,
    S_WAITS,
    S_DIVV,
    S_WAITV,
    S_FIN
  } state_e;

  typedef struct packed {
    logic cap;
    logic mul1;
    logic mul2;
    logic div_start;
    logic div_vel;
    logic take_step;
    logic take_vel;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/jdcs_div.sv -----
// Division by one million by reciprocal multiply: low product, then the quotient.
// Depends on jdcs_pkg.
module jdcs_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [jdcs_pkg::DivNumW-1:0]  num_i,
  output logic [jdcs_pkg::DivQuoW-1:0]  quo_o,
  output logic                          done_o
);

  logic [32:0] m_q;
  logic [49:0] lo_q;
  logic [19:0] quo_q;
  logic        s1_q;
  logic        done_q;
  logic [49:0] lo_prod;
  logic [49:0] hi_sum;

  // The low six bits only divide away the factor 64 of one million.
  always_comb begin
    lo_prod = 50'(num_i[38:6]) * 50'(jdcs_pkg::RecipLo);
    hi_sum  = 50'(m_q) * 50'(jdcs_pkg::RecipHi) + 50'(lo_q[49:17]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      done_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q  <= num_i[38:6];
      lo_q <= lo_prod;
    end
    if (s1_q) quo_q <= hi_sum[49:30];
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

// ----- rtl/jdcs_ctrl.sv -----
// Controller state machine sequencing capture, two multiply steps, two divisions
// and the final update. Depends on jdcs_pkg.
module jdcs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               teleop_active_i,
  input  jdcs_pkg::status_t  status_i,
  output logic               in_stall_o,
  output jdcs_pkg::cmd_t     cmd_o
);

  jdcs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jdcs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != jdcs_pkg::S_IDLE);
    unique case (state_q)
      jdcs_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          if (teleop_active_i) state_d = jdcs_pkg::S_MUL1;
        end
      end
      jdcs_pkg::S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = jdcs_pkg::S_MUL2;
      end
      jdcs_pkg::S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = jdcs_pkg::S_DIVS;
      end
      jdcs_pkg::S_DIVS: begin
        cmd_o.div_start = 1'b1;
        state_d         = jdcs_pkg::S_WAITS;
      end
      jdcs_pkg::S_WAITS: begin
        if (status_i.div_done) begin
          cmd_o.take_step = 1'b1;
          state_d         = jdcs_pkg::S_DIVV;
        end
      end
      jdcs_pkg::S_DIVV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_vel   = 1'b1;
        state_d         = jdcs_pkg::S_WAITV;
      end
      jdcs_pkg::S_WAITV: begin
        if (status_i.div_done) begin
          cmd_o.take_vel = 1'b1;
          state_d        = jdcs_pkg::S_FIN;
        end
      end
      jdcs_pkg::S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = jdcs_pkg::S_IDLE;
        end
      end
      default: state_d = jdcs_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- rtl/jdcs_dp.sv -----
// Datapath: configuration registers, sample registers, multipliers, held state
// and the output register. Depends on jdcs_pkg and jdcs_div.
module jdcs_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  jdcs_pkg::cmd_t                  cmd_i,
  output jdcs_pkg::status_t               status_o,
  input  logic                            cfg_we_i,
  input  logic [jdcs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [jdcs_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic signed [15:0]              steer_axis_i,
  input  logic signed [15:0]              throttle_axis_i,
  input  logic signed [15:0]              brake_axis_i,
  input  logic [8:0]                      buttons_i,
  input  logic [19:0]                     elapsed_us_i,
  input  logic                            teleop_active_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [17:0]              steering_angle_o,
  output logic [16:0]                     velocity_o,
  output logic signed [15:0]              acceleration_o,
  output logic [1:0]                      gear_o,
  output logic [1:0]                      indicator_o,
  output logic                            flash_light_o,
  output logic                            head_light_o,
  output logic                            honk_o
);

  // Configuration.
  logic        rle_q, inv_q, sep_q;
  logic [16:0] max_speed_q;
  logic [14:0] max_accel_q, max_decel_q;
  logic [17:0] max_steer_rate_q;
  logic [15:0] max_steer_angle_q;

  // Held state.
  logic signed [17:0] held_angle_q, held_angle_d;
  logic [16:0]        held_vel_q, held_vel_d;
  logic signed [15:0] held_acc_q, held_acc_d;
  logic [1:0]         gear_q, gear_d;
  logic               head_q, head_d;
  logic [4:0]         prev_q, prev_d;
  logic               was_teleop_q;

  // Sample and working registers.
  logic signed [15:0] steer_q, thr_q, brk_q;
  logic [8:0]         btn_q;
  logic [19:0]        us_q;
  logic signed [32:0] ang_prod_q;
  logic [37:0]        rate_prod_q;
  logic [30:0]        acc_prod_q;
  logic               acc_pos_q, acc_neg_q;
  logic signed [17:0] angle_q;
  logic signed [15:0] accel_q;
  logic [38:0]        vel_num_q;
  logic [18:0]        step_q;
  logic [16:0]        dv_q;

  // Output register.
  logic               out_valid_q;
  logic signed [17:0] out_angle_q, out_angle_d;
  logic [16:0]        out_vel_q;
  logic signed [15:0] out_acc_q;
  logic [1:0]         out_gear_q, out_ind_q;
  logic               out_flash_q, out_head_q, out_honk_q;

  // Divider.
  logic [jdcs_pkg::DivQuoW-1:0] quo;
  logic                         div_done;
  logic [38:0]                  div_num;

  assign div_num = cmd_i.div_vel ? vel_num_q : 39'(rate_prod_q);

  jdcs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .quo_o   (quo),
    .done_o  (div_done)
  );

  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // First multiply step: demand and the three products.
  logic signed [17:0] demand;
  logic               dem_pos, dem_neg;
  logic [16:0]        dem_mag;
  logic [14:0]        gain;

  always_comb begin
    demand  = sep_q ? (18'(thr_q) - 18'(brk_q)) : (18'(thr_q) + 18'(thr_q));
    dem_pos = (demand >= $signed({1'b0, jdcs_pkg::DeadzoneQ16}));
    dem_neg = (demand <= -$signed({1'b0, jdcs_pkg::DeadzoneQ16}));
    if (dem_neg) begin
      dem_mag = 17'(-demand - $signed({1'b0, jdcs_pkg::DeadzoneQ16}));
      gain    = max_decel_q;
    end else begin
      dem_mag = 17'(demand - $signed({1'b0, jdcs_pkg::DeadzoneQ16}));
      gain    = max_accel_q;
    end
  end

  // Second multiply step: rounded angle, acceleration and the velocity product.
  logic [31:0] ang_mag;
  logic [16:0] ang_round;
  logic [14:0] acc_mag;

  always_comb begin
    ang_mag   = ang_prod_q[32] ? 32'(-ang_prod_q) : 32'(ang_prod_q);
    ang_round = 17'((ang_mag + 32'd16384) >> 15);
    acc_mag   = (acc_pos_q || acc_neg_q) ? acc_prod_q[30:16] : 15'd0;
  end

  // Final update.
  logic signed [20:0] ang_hi, ang_lo, vel_sum;
  logic signed [17:0] ang_lim;
  logic               sp_up, sp_dn, gr_up, gr_dn, hl;
  logic               drive;

  always_comb begin
    ang_hi  = 21'(held_angle_q) + $signed({2'b0, step_q});
    ang_lo  = 21'(held_angle_q) - $signed({2'b0, step_q});
    ang_lim = angle_q;
    held_angle_d = held_angle_q;
    if (rle_q) begin
      if (21'(angle_q) > ang_hi) ang_lim = 18'(ang_hi);
      if (21'(angle_q) < ang_lo) ang_lim = 18'(ang_lo);
      held_angle_d = ang_lim;
    end
    out_angle_d = ang_lim;
    if (inv_q && gear_q == jdcs_pkg::GEAR_REVERSE) out_angle_d = -ang_lim;

    prev_d     = prev_q;
    held_acc_d = held_acc_q;
    held_vel_d = 17'd0;
    sp_up   = btn_q[0];
    sp_dn   = btn_q[1];
    vel_sum = '0;
    drive   = !(gear_q == jdcs_pkg::GEAR_PARK || gear_q == jdcs_pkg::GEAR_NEUTRAL);
    if (drive) begin
      vel_sum = 21'(held_vel_q);
      if (accel_q < 0) vel_sum = vel_sum - $signed({4'b0, dv_q});
      else vel_sum = vel_sum + $signed({4'b0, dv_q});
      if (sp_up && !prev_q[0]) vel_sum = vel_sum + $signed({12'b0, jdcs_pkg::SpeedStep});
      if (sp_dn && !prev_q[1]) vel_sum = vel_sum - $signed({12'b0, jdcs_pkg::SpeedStep});
      prev_d[1:0] = {sp_dn, sp_up};
      if (vel_sum > $signed({4'b0, max_speed_q})) held_vel_d = max_speed_q;
      else if (vel_sum < 0) held_vel_d = 17'd0;
      else held_vel_d = 17'(vel_sum);
      held_acc_d = accel_q;
    end

    gear_d = gear_q;
    gr_up  = btn_q[2];
    gr_dn  = btn_q[3];
    if (held_vel_d < jdcs_pkg::StopLimit) begin
      if (gr_up && !prev_q[2] && gear_d < jdcs_pkg::GEAR_DRIVE) gear_d = gear_d + 2'd1;
      if (gr_dn && !prev_q[3] && gear_d > jdcs_pkg::GEAR_REVERSE) gear_d = gear_d - 2'd1;
      prev_d[3:2] = {gr_dn, gr_up};
    end

    hl     = btn_q[7];
    head_d = head_q ^ (hl && !prev_q[4]);
    prev_d[4] = hl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rle_q             <= 1'b0;
      inv_q             <= 1'b0;
      sep_q             <= 1'b1;
      max_speed_q       <= '0;
      max_accel_q       <= '0;
      max_decel_q       <= '0;
      max_steer_rate_q  <= '0;
      max_steer_angle_q <= '0;
      held_angle_q      <= '0;
      held_vel_q        <= '0;
      held_acc_q        <= '0;
      gear_q            <= jdcs_pkg::GEAR_REVERSE;
      head_q            <= 1'b0;
      prev_q            <= '0;
      was_teleop_q      <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (jdcs_pkg::cfg_reg_e'(cfg_idx_i))
          jdcs_pkg::REG_RATE_LIMIT_ENABLE:   rle_q             <= cfg_data_i[0];
          jdcs_pkg::REG_INVERT_IN_REVERSE:   inv_q             <= cfg_data_i[0];
          jdcs_pkg::REG_SEPARATE_BRAKE_AXIS: sep_q             <= cfg_data_i[0];
          jdcs_pkg::REG_MAX_SPEED:           max_speed_q       <= cfg_data_i[16:0];
          jdcs_pkg::REG_MAX_ACCEL:           max_accel_q       <= cfg_data_i[14:0];
          jdcs_pkg::REG_MAX_DECEL:           max_decel_q       <= cfg_data_i[14:0];
          jdcs_pkg::REG_MAX_STEER_RATE:      max_steer_rate_q  <= cfg_data_i[17:0];
          jdcs_pkg::REG_MAX_STEER_ANGLE:     max_steer_angle_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.cap) begin
        was_teleop_q <= teleop_active_i;
        if (was_teleop_q && !teleop_active_i) begin
          held_vel_q <= '0;
          held_acc_q <= '0;
          head_q     <= 1'b0;
          gear_q     <= jdcs_pkg::GEAR_REVERSE;
        end
      end
      if (cmd_i.fin) begin
        held_angle_q <= held_angle_d;
        held_vel_q   <= held_vel_d;
        held_acc_q   <= held_acc_d;
        gear_q       <= gear_d;
        head_q       <= head_d;
        prev_q       <= prev_d;
      end
      if (cmd_i.fin) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      steer_q <= steer_axis_i;
      thr_q   <= throttle_axis_i;
      brk_q   <= brake_axis_i;
      btn_q   <= buttons_i;
      us_q    <= elapsed_us_i;
    end
    if (cmd_i.mul1) begin
      ang_prod_q  <= 33'(steer_q) * $signed({17'b0, max_steer_angle_q});
      rate_prod_q <= 38'(max_steer_rate_q) * 38'(us_q);
      acc_prod_q  <= 31'(31'(gain) * 31'(dem_mag));
      acc_pos_q   <= dem_pos;
      acc_neg_q   <= dem_neg;
    end
    if (cmd_i.mul2) begin
      angle_q   <= ang_prod_q[32] ? -$signed({1'b0, ang_round}) : $signed({1'b0, ang_round});
      accel_q   <= acc_neg_q ? -$signed({1'b0, acc_mag}) : $signed({1'b0, acc_mag});
      vel_num_q <= 39'(acc_mag) * 39'(us_q) + jdcs_pkg::HalfSec;
    end
    if (cmd_i.take_step) step_q <= quo[18:0];
    if (cmd_i.take_vel) dv_q <= quo[16:0];
    if (cmd_i.fin) begin
      out_angle_q <= out_angle_d;
      out_vel_q   <= held_vel_d;
      out_acc_q   <= held_acc_d;
      out_gear_q  <= gear_d;
      out_ind_q   <= btn_q[5:4];
      out_flash_q <= btn_q[6];
      out_head_q  <= head_d;
      out_honk_q  <= btn_q[8];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign steering_angle_o = out_angle_q;
  assign velocity_o       = out_vel_q;
  assign acceleration_o   = out_acc_q;
  assign gear_o           = out_gear_q;
  assign indicator_o      = out_ind_q;
  assign flash_light_o    = out_flash_q;
  assign head_light_o     = out_head_q;
  assign honk_o           = out_honk_q;

endmodule

// ----- rtl/joystick_drive_command_shaper.sv -----
// Joystick drive command shaper, top level.
// An active sample beat gives its command beat through the controller sequence of
// capture, two multiply steps, two divisions by one million and the final update.
// No new sample is taken until the sequence is through; a command beat still stalled
// at its end keeps the controller in its final state until that beat is taken.
// Inactive samples are captured and give no beat. Reset (asynchronous, active low)
// clears the held command, sets gear to reverse and restores register defaults.
module joystick_drive_command_shaper (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [jdcs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [jdcs_pkg::CfgDataW-1:0] cfg_data_i,
  // Joystick sample channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [15:0]            steer_axis_i,
  input  logic signed [15:0]            throttle_axis_i,
  input  logic signed [15:0]            brake_axis_i,
  input  logic [8:0]                    buttons_i,
  input  logic [19:0]                   elapsed_us_i,
  input  logic                          teleop_active_i,
  // Drive command channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [17:0]            steering_angle_o,
  output logic [16:0]                   velocity_o,
  output logic signed [15:0]            acceleration_o,
  output logic [1:0]                    gear_o,
  output logic [1:0]                    indicator_o,
  output logic                          flash_light_o,
  output logic                          head_light_o,
  output logic                          honk_o
);

  // The controller only sequences; all arithmetic and the held drive state live in the datapath.
  jdcs_pkg::cmd_t    cmd;
  jdcs_pkg::status_t status;

  jdcs_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .teleop_active_i (teleop_active_i),
    .status_i        (status),
    .in_stall_o      (in_stall_o),
    .cmd_o           (cmd)
  );

  // The output register lets a finished command beat wait while the next sample
  // is already being worked on.
  jdcs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .steer_axis_i     (steer_axis_i),
    .throttle_axis_i  (throttle_axis_i),
    .brake_axis_i     (brake_axis_i),
    .buttons_i        (buttons_i),
    .elapsed_us_i     (elapsed_us_i),
    .teleop_active_i  (teleop_active_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .steering_angle_o (steering_angle_o),
    .velocity_o       (velocity_o),
    .acceleration_o   (acceleration_o),
    .gear_o           (gear_o),
    .indicator_o      (indicator_o),
    .flash_light_o    (flash_light_o),
    .head_light_o     (head_light_o),
    .honk_o           (honk_o)
  );

endmodule

// ----- verif/tb.sv -----
// Self-checking bench for the joystick drive command shaper.
// Holds a command predictor class and plain driver tasks; needs only jdcs_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One joystick sample as the sender presents it.
  typedef struct {
    logic signed [15:0] steer;
    logic signed [15:0] throttle;
    logic signed [15:0] brake;
    logic [8:0]         buttons;
    logic [19:0]        elapsed_us;
    logic               active;
  } joy_sample_t;

  // One drive command at the widths of the output ports.
  typedef struct {
    logic [17:0] angle;
    logic [16:0] velocity;
    logic [15:0] accel;
    logic [1:0]  gear;
    logic [1:0]  indicator;
    logic        flash;
    logic        head;
    logic        honk;
  } drive_cmd_t;

  // Predicts the command for every accepted active sample and checks the returned beats.
  class drive_cmd_scoreboard;
    drive_cmd_t  expected_cmds[$];
    int unsigned errors;
    // Register copies.
    bit          rate_limit, invert_rev, separate_brake;
    longint      speed_cap, accel_full, decel_full, steer_rate, steer_full;
    // Vehicle state.
    longint      steer_hold, vel_hold, accel_hold;
    jdcs_pkg::gear_e gear;
    bit          headlight, was_active;
    logic [4:0]  last_btn;

    function new();
      errors = 0;
      rate_limit = 0; invert_rev = 0; separate_brake = 1;
      speed_cap = 0; accel_full = 0; decel_full = 0; steer_rate = 0; steer_full = 0;
      steer_hold = 0; vel_hold = 0; accel_hold = 0;
      gear = jdcs_pkg::GEAR_REVERSE; headlight = 0; was_active = 0; last_btn = '0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void write_reg(jdcs_pkg::cfg_reg_e idx, logic [17:0] value);
      case (idx)
        jdcs_pkg::REG_RATE_LIMIT_ENABLE:   rate_limit = value[0];
        jdcs_pkg::REG_INVERT_IN_REVERSE:   invert_rev = value[0];
        jdcs_pkg::REG_SEPARATE_BRAKE_AXIS: separate_brake = value[0];
        jdcs_pkg::REG_MAX_SPEED:           speed_cap = value[16:0];
        jdcs_pkg::REG_MAX_ACCEL:           accel_full = value[14:0];
        jdcs_pkg::REG_MAX_DECEL:           decel_full = value[14:0];
        jdcs_pkg::REG_MAX_STEER_RATE:      steer_rate = value[17:0];
        default:                           steer_full = value[15:0];
      endcase
    endfunction

    // Division rounded to nearest with halves away from zero.
    function longint round_div(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
    endfunction

    function void note_sample(joy_sample_t s);
      longint     ang, out_ang, slew, d, a, v, us;
      drive_cmd_t c;
      us = s.elapsed_us;
      // Dropping out of teleoperation clears the motion command and the headlight and sets gear to reverse.
      if (was_active && !s.active) begin
        vel_hold = 0; accel_hold = 0; headlight = 0; gear = jdcs_pkg::GEAR_REVERSE;
      end
      was_active = s.active;
      if (!s.active) return;

      ang = round_div(longint'(s.steer) * steer_full, 32768);
      if (rate_limit) begin
        slew = (steer_rate * us) / 1000000;
        if (ang > steer_hold + slew) ang = steer_hold + slew;
        if (ang < steer_hold - slew) ang = steer_hold - slew;
        steer_hold = ang;
      end
      out_ang = (invert_rev && gear == jdcs_pkg::GEAR_REVERSE) ? -ang : ang;

      if (gear == jdcs_pkg::GEAR_PARK || gear == jdcs_pkg::GEAR_NEUTRAL) begin
        vel_hold = 0;
      end else begin
        d = separate_brake ? longint'(s.throttle) - longint'(s.brake)
                           : 2 * longint'(s.throttle);
        a = 0;
        if (d >= 3277) a = (accel_full * (d - 3277)) >>> 16;
        else if (d <= -3277) a = -((decel_full * (-d - 3277)) >>> 16);
        v = vel_hold + round_div(a * us, 1000000);
        if (s.buttons[0] && !last_btn[0]) v += 284;
        if (s.buttons[1] && !last_btn[1]) v -= 284;
        last_btn[1:0] = s.buttons[1:0];
        if (v > speed_cap) v = speed_cap;
        else if (v < 0) v = 0;
        vel_hold = v;
        accel_hold = a;
      end

      // Gear steps only while the vehicle is nearly stopped.
      if (vel_hold < 11) begin
        if (s.buttons[2] && !last_btn[2] && gear != jdcs_pkg::GEAR_DRIVE)
          gear = jdcs_pkg::gear_e'(gear + 2'd1);
        if (s.buttons[3] && !last_btn[3] && gear > jdcs_pkg::GEAR_REVERSE)
          gear = jdcs_pkg::gear_e'(gear - 2'd1);
        last_btn[3:2] = s.buttons[3:2];
      end

      if (s.buttons[7] && !last_btn[4]) headlight = !headlight;
      last_btn[4] = s.buttons[7];

      c.angle = out_ang[17:0];
      c.velocity = vel_hold[16:0];
      c.accel = accel_hold[15:0];
      c.gear = gear;
      c.indicator = s.buttons[5:4];
      c.flash = s.buttons[6];
      c.head = headlight;
      c.honk = s.buttons[8];
      expected_cmds.push_back(c);
    endfunction

    task check_command(drive_cmd_t got);
      drive_cmd_t e;
      if (expected_cmds.size() == 0) begin
        report("command beat with no sample waiting for it");
        return;
      end
      e = expected_cmds.pop_front();
      if (got.angle !== e.angle)
        report($sformatf("steering_angle %0h, want %0h", got.angle, e.angle));
      if (got.velocity !== e.velocity)
        report($sformatf("velocity %0d, want %0d", got.velocity, e.velocity));
      if (got.accel !== e.accel)
        report($sformatf("acceleration %0h, want %0h", got.accel, e.accel));
      if (got.gear !== e.gear)
        report($sformatf("gear %0d, want %0d", got.gear, e.gear));
      if (got.indicator !== e.indicator)
        report($sformatf("indicator %0d, want %0d", got.indicator, e.indicator));
      if (got.flash !== e.flash) report("flash_light differs");
      if (got.head !== e.head) report("head_light differs");
      if (got.honk !== e.honk) report("honk differs");
    endtask
  endclass

  localparam longint CycleLimit = 3_000_000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [2:0]          cfg_idx_i = '0;
  logic [17:0]         cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic signed [15:0]  steer_axis_i = '0;
  logic signed [15:0]  throttle_axis_i = '0;
  logic signed [15:0]  brake_axis_i = '0;
  logic [8:0]          buttons_i = '0;
  logic [19:0]         elapsed_us_i = '0;
  logic                teleop_active_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic signed [17:0]  steering_angle_o;
  logic [16:0]         velocity_o;
  logic signed [15:0]  acceleration_o;
  logic [1:0]          gear_o;
  logic [1:0]          indicator_o;
  logic                flash_light_o;
  logic                head_light_o;
  logic                honk_o;

  drive_cmd_scoreboard cmd_board = new();
  longint              cycle_count = 0;
  logic [8:0]          held_buttons = '0;

  joystick_drive_command_shaper DUT (.*);

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // A hung block must not hang the run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver side. The stall pattern is drawn anew over the run among never stalling,
  // stalling now and then and stalling most of the time, so back pressure lands on
  // every phase of the block's work. Beats are checked with the pre-edge values.
  logic [1:0] stall_mode = '0;
  always @(posedge clk_i) begin
    drive_cmd_t got;
    if (out_valid_o && !out_stall_i) begin
      got.angle = steering_angle_o;
      got.velocity = velocity_o;
      got.accel = acceleration_o;
      got.gear = gear_o;
      got.indicator = indicator_o;
      got.flash = flash_light_o;
      got.head = head_light_o;
      got.honk = honk_o;
      cmd_board.check_command(got);
    end
    if (cycle_count % 64 == 0) stall_mode <= 2'($urandom_range(0, 2));
    case (stall_mode)
      2'd0:    out_stall_i <= 1'b0;
      2'd1:    out_stall_i <= ($urandom_range(0, 9) < 3);
      default: out_stall_i <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // Register write: one cycle with the write enable high, then the enable low again
  // before the task returns, mirrored in the predictor.
  task automatic write_reg(jdcs_pkg::cfg_reg_e idx, logic [17:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cmd_board.write_reg(idx, value);
    @(posedge clk_i);
  endtask

  // Hold off until every predicted command has come back, then let an inactive
  // sample still in flight drain out before anything else touches the block.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (cmd_board.expected_cmds.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_config(bit rl, bit inv, bit sep, logic [16:0] spd, logic [14:0] acc,
                            logic [14:0] dec, logic [17:0] rate, logic [15:0] full);
    write_reg(jdcs_pkg::REG_RATE_LIMIT_ENABLE, 18'(rl));
    write_reg(jdcs_pkg::REG_INVERT_IN_REVERSE, 18'(inv));
    write_reg(jdcs_pkg::REG_SEPARATE_BRAKE_AXIS, 18'(sep));
    write_reg(jdcs_pkg::REG_MAX_SPEED, 18'(spd));
    write_reg(jdcs_pkg::REG_MAX_ACCEL, 18'(acc));
    write_reg(jdcs_pkg::REG_MAX_DECEL, 18'(dec));
    write_reg(jdcs_pkg::REG_MAX_STEER_RATE, rate);
    write_reg(jdcs_pkg::REG_MAX_STEER_ANGLE, 18'(full));
  endtask

  // Present one sample beat and hold it until the block takes it.
  task automatic send_sample(joy_sample_t s);
    steer_axis_i <= s.steer;
    throttle_axis_i <= s.throttle;
    brake_axis_i <= s.brake;
    buttons_i <= s.buttons;
    elapsed_us_i <= s.elapsed_us;
    teleop_active_i <= s.active;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    cmd_board.note_sample(s);
  endtask

  task automatic send_fields(int st, int th, int br, int btn, int us, bit act);
    joy_sample_t s;
    s.steer = 16'(st);
    s.throttle = 16'(th);
    s.brake = 16'(br);
    s.buttons = 9'(btn);
    s.elapsed_us = 20'(us);
    s.active = act;
    send_sample(s);
  endtask

  // Mostly a well-formed drive session: buttons held for a while and then flipped,
  // samples at about the usual rate. A small share is noise of every kind.
  function automatic joy_sample_t random_sample();
    joy_sample_t s;
    int          pick;
    pick = $urandom_range(0, 99);
    s.active = (pick >= 4);
    s.steer = 16'($urandom);
    s.throttle = ($urandom_range(0, 4) == 0) ? 16'h7fff : 16'($urandom);
    s.brake = ($urandom_range(0, 3) == 0) ? 16'h8000 : 16'($urandom);
    if ($urandom_range(0, 2) == 0) s.throttle = 16'($urandom_range(0, 6000));
    if ($urandom_range(0, 2) == 0) s.brake = 16'($urandom_range(0, 6000));
    if (pick < 10) held_buttons = 9'($urandom);
    else if ($urandom_range(0, 2) == 0) held_buttons ^= 9'(1 << $urandom_range(0, 8));
    s.buttons = held_buttons;
    s.elapsed_us = (pick < 12) ? 20'($urandom) : 20'($urandom_range(2000, 60000));
    return s;
  endfunction

  initial begin
    int phase;
    int n;
    int gap;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the top extremes, slew limiting and inversion on.
    set_config(1'b1, 1'b1, 1'b1, 17'h1ffff, 15'd20480, 15'd20480, 18'h3ffff, 16'hffff);
    send_fields(-32768, 0, 0, 0, 1000000, 1'b1);         // full left, reverse inverts
    send_fields(32767, 32767, -32768, 9'h100, 0, 1'b1);  // zero elapsed: no slew room
    send_fields(32767, 32767, -32768, 9'h001, 1048575, 1'b1); // elapsed beyond one second
    send_fields(0, -32768, 32767, 9'h002, 1000000, 1'b1);
    send_fields(0, 0, 0, 9'h00c, 10000, 1'b1);           // both gear edges at once
    send_fields(0, 0, 0, 9'h000, 10000, 1'b1);
    send_fields(0, 0, 0, 9'h004, 10000, 1'b1);           // gear-up edge while still moving: gear stays
    send_fields(0, 32767, 0, 9'h030, 10000, 1'b1);       // full throttle while still in reverse
    send_fields(0, 0, 0, 9'h000, 10000, 1'b1);
    send_fields(100, 0, 0, 9'h004, 10000, 1'b1);         // gear-up edge again while still moving
    send_fields(-100, 32767, -32768, 9'h0c1, 1000000, 1'b1);
    send_fields(0, 3277, 0, 9'h040, 20000, 1'b1);        // deadzone edge
    send_fields(0, 3276, 0, 9'h000, 20000, 1'b1);
    send_fields(0, 0, 3277, 9'h008, 20000, 1'b1);        // gear button while moving
    send_fields(0, 0, 0, 9'h080, 20000, 1'b0);           // leaving teleoperation
    send_fields(0, 0, 0, 9'h000, 20000, 1'b0);           // plain inactive sample
    send_fields(5000, 0, 0, 9'h1ff, 20000, 1'b1);
    drain();
    set_config(1'b0, 1'b0, 1'b0, 17'd0, 15'd0, 15'd0, 18'd0, 16'd0);
    send_fields(32767, 32767, 0, 9'h0ff, 20000, 1'b1);
    send_fields(-32768, -32768, 0, 9'h000, 20000, 1'b1);
    send_fields(0, 1638, 0, 9'h004, 20000, 1'b1);        // throttle-only deadzone edge
    drain();

    // Random part: several register settings, bursts with random gaps.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(1'b1, 1'b1, 1'b0, 17'h1ffff, 15'h7fff, 15'h7fff, 18'h3ffff, 16'hffff);
        1: set_config(1'b0, 1'b0, 1'b1, 17'd3000, 15'd20480, 15'd1, 18'd1, 16'd1);
        default: set_config(1'($urandom), 1'($urandom), 1'($urandom), 17'($urandom),
                            15'($urandom_range(0, 20480)), 15'($urandom_range(0, 20480)),
                            18'($urandom), 16'($urandom));
      endcase
      n = 0;
      while (n < 300) begin
        gap = $urandom_range(1, 12);
        repeat (gap) begin
          send_sample(random_sample());
          n++;
        end
        if ($urandom_range(0, 2) != 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end
      end
      drain();
    end

    if (cmd_board.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- joystick_drive_command_shaper.f -----
rtl/jdcs_pkg.sv
rtl/jdcs_div.sv
rtl/jdcs_ctrl.sv
rtl/jdcs_dp.sv
rtl/joystick_drive_command_shaper.sv
verif/tb.sv
